// ===== design/lkvc_pkg.sv =====
// package for the lru key/value cache: sizes and word types
// used by lru_key_value_cache; depends on nothing
package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AGE_W   = IDX_W;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int KEY_W   = 16;
  localparam int VAL_W   = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic {
    MODE_GET = 1'b0,
    MODE_PUT = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t                    mode;
    logic        [KEY_W-1:0]  key;
    logic signed [VAL_W-1:0]  data_in;
  } cache_in_t;

  typedef struct packed {
    logic                     hit;
    logic signed [VAL_W-1:0]  read_value;
    logic                     evicted;
  } cache_out_t;

endpackage

// ===== design/lru_key_value_cache.sv =====
// lru key/value cache top level: register-held table, lookup and update
// depends on lkvc_pkg
//
// a word's result is registered once the result register is free or being read
// throughput: one word per cycle while no result waits on out_ready; the parallel key compare
//   and the age update sit between the input register and the result register
// reset (rst_n low, synchronous): table empty, all ages zero, capacity 16
module lru_key_value_cache
  import lkvc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  cache_in_t        in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output cache_out_t       out_word,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  logic                     s1_valid_r;
  cache_in_t                s1_word_r;
  logic                     out_valid_r;
  cache_out_t               out_word_r;
  logic [CAP_W-1:0]         capacity_r;

  logic [ENTRIES-1:0]       valid_r, valid_nxt;
  logic [KEY_W-1:0]         key_r   [ENTRIES];
  logic [KEY_W-1:0]         key_nxt [ENTRIES];
  logic [VAL_W-1:0]         val_r   [ENTRIES];
  logic [VAL_W-1:0]         val_nxt [ENTRIES];
  logic [AGE_W-1:0]         age_r   [ENTRIES];
  logic [AGE_W-1:0]         age_nxt [ENTRIES];
  logic [CNT_W-1:0]         count_r, count_nxt;
  cache_out_t               res;

  logic                     s1_adv;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // lookup and update for the word in the input register
  always_comb begin
    logic             hit;
    logic [IDX_W-1:0] found;
    logic             have_free;
    logic [IDX_W-1:0] free_idx;
    logic             any_victim;
    logic [IDX_W-1:0] victim;
    logic [AGE_W-1:0] oldest;
    logic [CMP_W-1:0] eff_cap;
    logic             do_touch;
    logic             all_older;
    logic [IDX_W-1:0] sel;
    logic [AGE_W-1:0] old_rank;

    hit        = 1'b0;
    found      = '0;
    have_free  = 1'b0;
    free_idx   = '0;
    any_victim = 1'b0;
    victim     = '0;
    do_touch   = 1'b0;
    all_older  = 1'b0;
    sel        = '0;
    old_rank   = '0;
    // ranks of valid entries are 0..count-1, so the oldest is count-1
    oldest     = AGE_W'(count_r - CNT_W'(1));

    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && key_r[i] == s1_word_r.key) begin
        hit   = 1'b1;
        found = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        have_free = 1'b1;
        free_idx  = IDX_W'(i);
      end
      if (valid_r[i] && age_r[i] == oldest) begin
        any_victim = 1'b1;
        victim     = IDX_W'(i);
      end
    end

    if (capacity_r == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(capacity_r) > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = CMP_W'(capacity_r);
    end
    if (CMP_W'(count_r) >= eff_cap) begin
      have_free = 1'b0;
    end

    valid_nxt = valid_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    age_nxt   = age_r;
    count_nxt = count_r;

    res.hit        = hit;
    res.read_value = '0;
    res.evicted    = 1'b0;

    if (s1_word_r.mode == MODE_GET) begin
      if (hit) begin
        res.read_value = val_r[found];
        do_touch       = 1'b1;
        sel            = found;
        old_rank       = age_r[found];
      end
    end else if (hit) begin
      val_nxt[found] = s1_word_r.data_in;
      do_touch       = 1'b1;
      sel            = found;
      old_rank       = age_r[found];
    end else if (have_free) begin
      // new entry: every valid entry grows one rank older
      do_touch            = 1'b1;
      all_older           = 1'b1;
      sel                 = free_idx;
      valid_nxt[free_idx] = 1'b1;
      key_nxt[free_idx]   = s1_word_r.key;
      val_nxt[free_idx]   = s1_word_r.data_in;
      count_nxt           = count_r + CNT_W'(1);
    end else if (any_victim) begin
      do_touch        = 1'b1;
      sel             = victim;
      old_rank        = age_r[victim];
      key_nxt[victim] = s1_word_r.key;
      val_nxt[victim] = s1_word_r.data_in;
      res.evicted     = 1'b1;
    end

    if (do_touch) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_r[i] && IDX_W'(i) != sel && (all_older || age_r[i] < old_rank)) begin
          age_nxt[i] = age_r[i] + AGE_W'(1);
        end
      end
      age_nxt[sel] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      capacity_r  <= CAP_RESET;
      valid_r     <= '0;
      count_r     <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        valid_r     <= valid_nxt;
        count_r     <= count_nxt;
        age_r       <= age_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_word_r <= in_word;
    end
    if (s1_adv) begin
      out_word_r <= res;
      key_r      <= key_nxt;
      val_r      <= val_nxt;
    end
  end

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for lru_key_value_cache: directed and random get/put traffic
// against an in-bench model of the lru table, with random idling on both channels
// depends on lkvc_pkg and the design sources
module testbench;
  import lkvc_pkg::*;

  localparam int POOL_MAX = 24;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  cache_in_t        in_word;
  logic             out_valid;
  logic             out_ready;
  cache_out_t       out_word;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  lru_key_value_cache u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // bench copy of the table
  logic                    tbl_valid [ENTRIES];
  logic        [KEY_W-1:0] tbl_key   [ENTRIES];
  logic signed [VAL_W-1:0] tbl_value [ENTRIES];
  int                      tbl_age   [ENTRIES];
  int                      tbl_count;
  logic        [CAP_W-1:0] cap_setting;

  cache_out_t       pending_results [$];
  int               send_gap_pct;
  int               recv_stall_pct;
  int               mismatch_count;
  logic [KEY_W-1:0] key_pool [POOL_MAX];
  int               pool_size;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("lru_key_value_cache verification failed");
    $finish;
  end

  // make entry idx the newest; entries newer than old_rank age by one
  function automatic void promote(input int idx, input int old_rank);
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_valid[i] && i != idx && tbl_age[i] < old_rank) tbl_age[i] = tbl_age[i] + 1;
    end
    tbl_age[idx] = 0;
  endfunction

  function automatic cache_out_t predict_access(input cache_in_t w);
    cache_out_t r;
    logic       found;
    logic       free_ok;
    int         slot;
    int         limit;
    r       = '0;
    found   = 1'b0;
    free_ok = 1'b0;
    slot    = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!found && tbl_valid[i] && tbl_key[i] == w.key) begin
        found = 1'b1;
        slot  = i;
      end
    end
    r.hit = found;
    if (w.mode == MODE_GET) begin
      if (found) begin
        r.read_value = tbl_value[slot];
        promote(slot, tbl_age[slot]);
      end
    end else if (found) begin
      tbl_value[slot] = w.data_in;
      promote(slot, tbl_age[slot]);
    end else begin
      limit = int'(cap_setting);
      if (limit == 0) limit = 1;
      if (limit > ENTRIES) limit = ENTRIES;
      if (tbl_count < limit) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!free_ok && !tbl_valid[i]) begin
            free_ok = 1'b1;
            slot    = i;
          end
        end
      end
      if (free_ok) begin
        promote(slot, ENTRIES);
        tbl_valid[slot] = 1'b1;
        tbl_key[slot]   = w.key;
        tbl_value[slot] = w.data_in;
        tbl_count++;
      end else if (tbl_count > 0) begin
        // victim is the valid entry with the oldest rank, lowest index on a tie
        slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_valid[i] && (slot < 0 || tbl_age[i] > tbl_age[slot])) slot = i;
        end
        promote(slot, tbl_age[slot]);
        tbl_key[slot]   = w.key;
        tbl_value[slot] = w.data_in;
        r.evicted       = 1'b1;
      end
    end
    return r;
  endfunction

  // result side: random stalls and comparison against the oldest prediction
  always @(posedge clk) begin
    cache_out_t want;
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word hit=%0b read_value=%0d evicted=%0b", $time,
                 out_word.hit, out_word.read_value, out_word.evicted);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_word.hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, out_word.hit);
          mismatch_count++;
        end
        if (out_word.read_value !== want.read_value) begin
          $display("%0t: read_value expected %0d actual %0d", $time, want.read_value,
                   out_word.read_value);
          mismatch_count++;
        end
        if (out_word.evicted !== want.evicted) begin
          $display("%0t: evicted expected %0b actual %0b", $time, want.evicted,
                   out_word.evicted);
          mismatch_count++;
        end
      end
    end
  end

  // valid stays high after acceptance until the next word or a drain
  task automatic send_word(input mode_t m, input logic [KEY_W-1:0] k,
                           input logic signed [VAL_W-1:0] d);
    cache_in_t w;
    w.mode    = m;
    w.key     = k;
    w.data_in = d;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_access(w));
  endtask

  task automatic drain_cache();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] v);
    drain_cache();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    cap_setting  = v;
  endtask

  task automatic test_empty_table();
    send_word(MODE_GET, 16'h0000, 32'sh7FFF_FFFF);
    send_word(MODE_GET, 16'hFFFF, 32'sh8000_0000);
  endtask

  task automatic test_get_and_update();
    send_word(MODE_PUT, 16'h0000, 32'sh7FFF_FFFF);
    send_word(MODE_PUT, 16'hFFFF, 32'sh8000_0000);
    send_word(MODE_GET, 16'h0000, 32'sh0000_0000);
    send_word(MODE_GET, 16'hFFFF, 32'shFFFF_FFFF);
    send_word(MODE_PUT, 16'h0000, 32'sh0000_0000);
    send_word(MODE_GET, 16'h0000, 32'sh1234_5678);
    send_word(MODE_GET, 16'h5A5A, 32'shFFFF_FFFF);
    send_word(MODE_PUT, 16'hA5A5, 32'shFFFF_FFFF);
  endtask

  // table holds three entries when the capacity drops under the count
  task automatic test_capacity_edges();
    set_capacity(5'd1);
    send_word(MODE_PUT, 16'h1111, 32'sh0000_0001);
    send_word(MODE_GET, 16'hFFFF, 32'sh0000_0000);
    send_word(MODE_PUT, 16'h2222, 32'sh0000_0002);
    send_word(MODE_PUT, 16'h0000, 32'sh0000_0003);
    set_capacity(5'd0);
    send_word(MODE_PUT, 16'h3333, 32'sh0000_0004);
    send_word(MODE_GET, 16'h3333, 32'sh0000_0000);
    send_word(MODE_PUT, 16'h3333, 32'sh0000_0005);
    set_capacity(5'd31);
    send_word(MODE_PUT, 16'h4444, 32'sh0000_0006);
    send_word(MODE_PUT, 16'h5555, 32'sh0000_0007);
    send_word(MODE_GET, 16'h2222, 32'sh0000_0000);
  endtask

  // mostly keys from a small pool so gets hit and new puts evict
  task automatic test_random_traffic(input logic [CAP_W-1:0] cap, input int n_words);
    int eff;
    set_capacity(cap);
    eff = (cap == 0) ? 1 : ((int'(cap) > ENTRIES) ? ENTRIES : int'(cap));
    pool_size = eff + $urandom_range(1, 8);
    if (pool_size > POOL_MAX) pool_size = POOL_MAX;
    for (int i = 0; i < pool_size; i++) key_pool[i] = KEY_W'($urandom);
    for (int i = 0; i < n_words; i++) begin
      send_word(($urandom_range(99) < 55) ? MODE_PUT : MODE_GET,
                ($urandom_range(99) < 85) ? key_pool[$urandom_range(pool_size - 1)]
                                          : KEY_W'($urandom),
                VAL_W'($urandom));
    end
  endtask

  initial begin
    logic [CAP_W-1:0] caps [12];
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_word        = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    send_gap_pct   = 31;
    recv_stall_pct = 47;
    mismatch_count = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_value[i] = '0;
      tbl_age[i]   = 0;
    end
    tbl_count   = 0;
    cap_setting = CAP_RESET;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_get_and_update();
    test_capacity_edges();

    caps[0] = 5'd16;
    caps[1] = 5'd1;
    caps[2] = 5'd31;
    caps[3] = 5'd0;
    for (int i = 4; i < 12; i++) caps[i] = CAP_W'($urandom_range(0, 31));
    caps[6] = 5'd2;
    for (int i = 0; i < 12; i++) begin
      if (i == 4) begin
        send_gap_pct   = 47;
        recv_stall_pct = 31;
      end else if (i == 8) begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      test_random_traffic(caps[i], 95);
    end

    drain_cache();
    if (mismatch_count == 0) begin
      $display("lru_key_value_cache verification clean");
    end else begin
      $display("lru_key_value_cache verification failed");
    end
    $finish;
  end

endmodule
